### hdl/fixed_timestep_catchup_scheduler_assert.svh
// assertion macros shared by the scheduler rtl
// needs a clock and an active-low reset name at each use
`ifndef FIXED_TIMESTEP_CATCHUP_SCHEDULER_ASSERT_SVH
`define FIXED_TIMESTEP_CATCHUP_SCHEDULER_ASSERT_SVH

// property must hold at every edge outside reset
`define FTCS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition must never be seen outside reset
`define FTCS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

### hdl/ftcs_pkg.sv
// types, constants and register codes of the fixed-timestep scheduler
// no dependencies; used by every rtl module and interface
package ftcs_pkg;

  localparam int unsigned TIME_W   = 64;
  localparam int unsigned STEP_W   = 32;
  localparam int unsigned BUDGET_W = 8;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [STEP_W-1:0]   FIXED_STEP_RST = 32'd16667;
  localparam logic [BUDGET_W-1:0] MAX_BUDGET_RST = 8'd200;
  localparam logic [BUDGET_W-1:0] REFILL_RST     = 8'd4;

  typedef enum logic [1:0] {
    REG_FIXED_STEP = 2'd0,
    REG_MAX_BUDGET = 2'd1,
    REG_REFILL     = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [STEP_W-1:0]   fixed_step_us;
    logic [BUDGET_W-1:0] max_budget;
    logic [BUDGET_W-1:0] refill_per_frame;
  } cfg_t;

  typedef enum logic [1:0] {
    DIV_BY_STEP   = 2'd0,
    DIV_BY_BUDGET = 2'd1,
    DIV_BY_WIDE   = 2'd2
  } div_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_EVAL,
    S_DIV_N,
    S_CHECK_N,
    S_DIV_STEP,
    S_START_N2,
    S_DIV_N2,
    S_FINISH,
    S_OUT
  } state_e;

  typedef struct packed {
    logic     accept;
    logic     diff;
    logic     div_start;
    div_sel_e div_sel;
    logic     cap_n;
    logic     cap_step;
    logic     load_step;
    logic     refill;
    logic     refill_zero;
    logic     res_upd;
    logic     res_zero;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_adv;
    logic not_due;
    logic budget_zero;
    logic n_over;
    logic div_done;
  } ctrl_status_t;

endpackage

### hdl/ftcs_stream_if.sv
// valid/ready channel interfaces for query/advance items and results
// depends on ftcs_pkg for field widths
interface ftcs_in_if;
  import ftcs_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [TIME_W-1:0] now_us;
  logic [TIME_W-1:0] advance_us;

  modport source (output valid, output cmd, output now_us, output advance_us, input ready);
  modport sink (input valid, input cmd, input now_us, input advance_us, output ready);
endinterface

interface ftcs_out_if;
  import ftcs_pkg::*;
  logic                valid;
  logic                ready;
  logic [BUDGET_W-1:0] iterations;
  logic [TIME_W-1:0]   step_us;

  modport source (output valid, output iterations, output step_us, input ready);
  modport sink (input valid, input iterations, input step_us, output ready);
endinterface

### hdl/ftcs_cfg_regs.sv
// apb-style configuration registers: fixed step, budget cap, refill
// depends on ftcs_pkg
module ftcs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ftcs_pkg::PADDR_W-1:0]  paddr,
  input  logic [ftcs_pkg::PDATA_W-1:0]  pwdata,
  output logic [ftcs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output ftcs_pkg::cfg_t                cfg_o
);
  import ftcs_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fixed_step_us    <= FIXED_STEP_RST;
      cfg_q.max_budget       <= MAX_BUDGET_RST;
      cfg_q.refill_per_frame <= REFILL_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_FIXED_STEP: cfg_q.fixed_step_us    <= pwdata[STEP_W-1:0];
        REG_MAX_BUDGET: cfg_q.max_budget       <= pwdata[BUDGET_W-1:0];
        REG_REFILL:     cfg_q.refill_per_frame <= pwdata[BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FIXED_STEP: prdata = cfg_q.fixed_step_us;
      REG_MAX_BUDGET: prdata = {{(PDATA_W-BUDGET_W){1'b0}}, cfg_q.max_budget};
      REG_REFILL:     prdata = {{(PDATA_W-BUDGET_W){1'b0}}, cfg_q.refill_per_frame};
      default:        prdata = '0;
    endcase
  end

endmodule

### hdl/ftcs_div.sv
// radix-2 restoring divider giving ceil(a / d) as (a - 1) / d + 1
// depends on ftcs_pkg; one quotient bit per cycle
`include "fixed_timestep_catchup_scheduler_assert.svh"
module ftcs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ftcs_pkg::TIME_W-1:0] dividend_i,
  input  logic [ftcs_pkg::TIME_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [ftcs_pkg::TIME_W-1:0] quot_o
);
  import ftcs_pkg::*;

  localparam int unsigned CNT_W = $clog2(TIME_W);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [TIME_W-1:0] rem_q, dq_q, d_q;

  logic [TIME_W:0]   shifted;
  logic [TIME_W+1:0] trial;
  logic              ge;

  // dq_q shifts dividend bits out at the top and quotient bits in at the bottom
  assign shifted = {rem_q, dq_q[TIME_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, d_q};
  assign ge      = !trial[TIME_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(TIME_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dq_q  <= dividend_i - 1'b1;
      d_q   <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? trial[TIME_W-1:0] : shifted[TIME_W-1:0];
      dq_q  <= {dq_q[TIME_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q + 1'b1;

  `FTCS_ASSERT_NEVER(a_no_restart, clk_i, rst_ni, start_i && busy_q, "divider restarted while busy")
  `FTCS_ASSERT(a_done_single, clk_i, rst_ni, done_q |=> !done_q, "divider done longer than a cycle")

endmodule

### hdl/ftcs_datapath.sv
// scheduler datapath: time state, budget, divider operands, result registers
// depends on ftcs_pkg, ftcs_div; driven by ftcs_ctrl commands
`include "fixed_timestep_catchup_scheduler_assert.svh"
module ftcs_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_cmd_i,
  input  logic [ftcs_pkg::TIME_W-1:0]   now_us_i,
  input  logic [ftcs_pkg::TIME_W-1:0]   advance_us_i,
  input  ftcs_pkg::cfg_t                cfg_i,
  input  ftcs_pkg::ctrl_cmd_t           cmd_i,
  output ftcs_pkg::ctrl_status_t        status_o,
  output logic [ftcs_pkg::BUDGET_W-1:0] iterations_o,
  output logic [ftcs_pkg::TIME_W-1:0]   step_us_o
);
  import ftcs_pkg::*;

  logic [TIME_W-1:0]   last_q, now_q, e_q, n_q, step_q, out_step_q;
  logic                first_q, behind_q, res_zero_q;
  logic [BUDGET_W-1:0] budget_q, out_iter_q;

  logic [STEP_W-1:0]   step_eff;
  logic [TIME_W:0]     diff;
  logic [TIME_W-1:0]   divisor, quot;
  logic                div_done, n_over;
  logic [BUDGET_W-1:0] spent, remain, budget_next;
  logic                spent_over;
  logic [BUDGET_W:0]   refill_sum;

  // a zero step behaves as one microsecond
  assign step_eff = (cfg_i.fixed_step_us == '0) ? STEP_W'(1) : cfg_i.fixed_step_us;
  assign diff     = {1'b0, now_q} - {1'b0, last_q};
  assign n_over   = (|n_q[TIME_W-1:BUDGET_W]) || (n_q[BUDGET_W-1:0] > budget_q);

  always_comb begin
    case (cmd_i.div_sel)
      DIV_BY_STEP:   divisor = {{(TIME_W-STEP_W){1'b0}}, step_eff};
      DIV_BY_BUDGET: divisor = {{(TIME_W-BUDGET_W){1'b0}}, budget_q};
      default:       divisor = step_q;
    endcase
  end

  ftcs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (e_q),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // debit by the spent count (floor at zero), add refill, clip to the cap
  always_comb begin
    spent       = cmd_i.refill_zero ? '0 : n_q[BUDGET_W-1:0];
    spent_over  = cmd_i.refill_zero ? 1'b0 : n_over;
    remain      = spent_over ? '0 : budget_q - spent;
    refill_sum  = {1'b0, remain} + {1'b0, cfg_i.refill_per_frame};
    budget_next = (refill_sum > {1'b0, cfg_i.max_budget}) ? cfg_i.max_budget
                                                          : refill_sum[BUDGET_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      first_q  <= 1'b1;
      budget_q <= MAX_BUDGET_RST;
    end else begin
      if (cmd_i.accept) begin
        if (in_cmd_i) begin
          last_q <= last_q + advance_us_i;
        end else if (first_q) begin
          last_q  <= now_us_i;
          first_q <= 1'b0;
        end
      end
      if (cmd_i.refill) begin
        budget_q <= budget_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      now_q <= now_us_i;
    end
    if (cmd_i.diff) begin
      e_q      <= diff[TIME_W-1:0];
      behind_q <= diff[TIME_W];
    end
    if (cmd_i.cap_n) begin
      n_q <= quot;
    end
    if (cmd_i.load_step) begin
      step_q <= {{(TIME_W-STEP_W){1'b0}}, step_eff};
    end else if (cmd_i.cap_step) begin
      step_q <= quot;
    end
    if (cmd_i.res_upd) begin
      res_zero_q <= cmd_i.res_zero;
    end
    if (cmd_i.load_out) begin
      out_iter_q <= res_zero_q ? '0 : n_q[BUDGET_W-1:0];
      out_step_q <= res_zero_q ? '0 : step_q;
    end
  end

  assign status_o.in_adv      = in_cmd_i;
  assign status_o.not_due     = behind_q || (e_q < {{(TIME_W-STEP_W){1'b0}}, step_eff});
  assign status_o.budget_zero = (budget_q == '0);
  assign status_o.n_over      = n_over;
  assign status_o.div_done    = div_done;

  assign iterations_o = out_iter_q;
  assign step_us_o    = out_step_q;

  // after any widening the count always fits the budget it is debited from
  `FTCS_ASSERT_NEVER(a_debit_fits, clk_i, rst_ni, cmd_i.refill && !cmd_i.refill_zero && n_over, "debit exceeds budget")

endmodule

### hdl/ftcs_ctrl.sv
// scheduler controller: sequences difference, divisions, refill and output
// depends on ftcs_pkg; commands ftcs_datapath
`include "fixed_timestep_catchup_scheduler_assert.svh"
module ftcs_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  ftcs_pkg::ctrl_status_t status_i,
  output ftcs_pkg::ctrl_cmd_t    cmd_o
);
  import ftcs_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.div_sel = DIV_BY_STEP;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.in_adv) begin
            cmd_o.res_upd  = 1'b1;
            cmd_o.res_zero = 1'b1;
            state_d        = S_OUT;
          end else begin
            state_d = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = S_EVAL;
      end
      S_EVAL: begin
        if (status_i.not_due) begin
          cmd_o.res_upd  = 1'b1;
          cmd_o.res_zero = 1'b1;
          state_d        = S_OUT;
        end else if (status_i.budget_zero) begin
          cmd_o.refill      = 1'b1;
          cmd_o.refill_zero = 1'b1;
          cmd_o.res_upd     = 1'b1;
          cmd_o.res_zero    = 1'b1;
          state_d           = S_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_BY_STEP;
          cmd_o.load_step = 1'b1;
          state_d         = S_DIV_N;
        end
      end
      S_DIV_N: begin
        if (status_i.div_done) begin
          cmd_o.cap_n = 1'b1;
          state_d     = S_CHECK_N;
        end
      end
      S_CHECK_N: begin
        if (status_i.n_over) begin
          // widen the step so the budget covers the elapsed time
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_BY_BUDGET;
          state_d         = S_DIV_STEP;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_DIV_STEP: begin
        if (status_i.div_done) begin
          cmd_o.cap_step = 1'b1;
          state_d        = S_START_N2;
        end
      end
      S_START_N2: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_BY_WIDE;
        state_d         = S_DIV_N2;
      end
      S_DIV_N2: begin
        if (status_i.div_done) begin
          cmd_o.cap_n = 1'b1;
          state_d     = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.refill   = 1'b1;
        cmd_o.res_upd  = 1'b1;
        cmd_o.res_zero = 1'b0;
        state_d        = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `FTCS_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q != S_IDLE), "accepted item left controller idle")
  `FTCS_ASSERT_NEVER(a_load_over_pending, clk_i, rst_ni, cmd_o.load_out && out_valid_q && !out_ready_i, "result overwrote a pending transfer")

endmodule

### hdl/fixed_timestep_catchup_scheduler.sv
// top level of the fixed-timestep catch-up scheduler
// depends on ftcs_pkg, ftcs_stream_if, ftcs_cfg_regs, ftcs_datapath, ftcs_ctrl
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    cmd, now_us, advance_us
//   out_o    out  valid/ready    iterations, step_us
//   apb      in   psel/penable   paddr, pwdata, prdata (fixed step, cap, refill)
//
// advance: S_IDLE straight to S_OUT; query not due or zero budget: S_DIFF, S_EVAL, S_OUT
// due query: one pass of the shared radix-2 divider, counting the due steps
// budget overrun: three divider passes (count, widened step, recount)
// one item in flight; the next is taken once its result sits in the output register
// reset zeroes last update time, sets first-query flag, fills budget; no clearing pass
module fixed_timestep_catchup_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ftcs_in_if.sink                       in_i,
  ftcs_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ftcs_pkg::PADDR_W-1:0]  paddr,
  input  logic [ftcs_pkg::PDATA_W-1:0]  pwdata,
  output logic [ftcs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import ftcs_pkg::*;

  cfg_t         cfg;
  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  logic         in_ready, out_valid;

  ftcs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ftcs_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_cmd_i     (in_i.cmd),
    .now_us_i     (in_i.now_us),
    .advance_us_i (in_i.advance_us),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .status_o     (status),
    .iterations_o (out_o.iterations),
    .step_us_o    (out_o.step_us)
  );

  ftcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

### tb/fixed_timestep_catchup_scheduler_test.sv
// self-checking testbench for the fixed-timestep catch-up scheduler
// depends on ftcs_pkg, ftcs_stream_if and the scheduler rtl; predicts each result in place
`timescale 1ns / 100ps

module fixed_timestep_catchup_scheduler_test;
  import ftcs_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 2_000_000;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned ITEMS_PER_PHASE = 180;
  localparam int unsigned HOLD_CYCLES     = 400;

  localparam logic CMD_QUERY   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;
  typedef enum logic [2:0] {RX_OPEN, RX_RANDOM, RX_TOGGLE, RX_STALL, RX_HOLD} rx_mode_e;

  typedef struct packed {
    logic [BUDGET_W-1:0] iterations;
    logic [TIME_W-1:0]   step_us;
  } update_t;

  typedef struct packed {
    row_kind_e         kind;
    logic              cmd;
    logic [TIME_W-1:0] now_us;
    logic [TIME_W-1:0] advance_us;
    reg_idx_e          reg_sel;
    logic [31:0]       reg_val;
    logic              has_exp;
    update_t           exp_upd;
  } dir_row_t;

  // reset settings: step 16667, cap 200, refill 4
  dir_row_t directed_rows [24] = '{
    // first query latches now as the last update time
    '{ROW_ITEM, CMD_QUERY, 64'd1000, 64'd0, REG_FIXED_STEP, 32'd0, 1'b1, '{8'd0, 64'd0}},
    '{ROW_ITEM, CMD_QUERY, 64'd17666, 64'd0, REG_FIXED_STEP, 32'd0, 1'b1, '{8'd0, 64'd0}},
    '{ROW_ITEM, CMD_QUERY, 64'd17667, 64'd0, REG_FIXED_STEP, 32'd0, 1'b1, '{8'd1, 64'd16667}},
    // now behind the last update
    '{ROW_ITEM, CMD_QUERY, 64'd999, 64'd0, REG_FIXED_STEP, 32'd0, 1'b1, '{8'd0, 64'd0}},
    '{ROW_ITEM, CMD_ADVANCE, 64'd0, 64'd16667, REG_FIXED_STEP, 32'd0, 1'b1, '{8'd0, 64'd0}},
    '{ROW_ITEM, CMD_QUERY, 64'd67663, 64'd0, REG_FIXED_STEP, 32'd0, 1'b0, '{8'd0, 64'd0}},
    '{ROW_ITEM, CMD_ADVANCE, 64'd0, 64'd50001, REG_FIXED_STEP, 32'd0, 1'b1, '{8'd0, 64'd0}},
    // 250 steps due against a budget of 200, then again against the refill
    '{ROW_ITEM, CMD_QUERY, 64'd4234418, 64'd0, REG_FIXED_STEP, 32'd0, 1'b0, '{8'd0, 64'd0}},
    '{ROW_ITEM, CMD_QUERY, 64'd4234418, 64'd0, REG_FIXED_STEP, 32'd0, 1'b0, '{8'd0, 64'd0}},
    // advance by all ones wraps the last update time back by one
    '{ROW_ITEM, CMD_ADVANCE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      REG_FIXED_STEP, 32'd0, 1'b1, '{8'd0, 64'd0}},
    '{ROW_ITEM, CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      REG_FIXED_STEP, 32'd0, 1'b0, '{8'd0, 64'd0}},
    '{ROW_ITEM, CMD_QUERY, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, REG_FIXED_STEP, 32'd0, 1'b1,
      '{8'd0, 64'd0}},
    '{ROW_ITEM, CMD_ADVANCE, 64'd0, 64'd0, REG_FIXED_STEP, 32'd0, 1'b1, '{8'd0, 64'd0}},
    '{ROW_ITEM, CMD_ADVANCE, 64'd0, 64'hFFFF_FFFF_FFFE_F7AD, REG_FIXED_STEP, 32'd0, 1'b1,
      '{8'd0, 64'd0}},
    '{ROW_ITEM, CMD_QUERY, 64'd0, 64'd0, REG_FIXED_STEP, 32'd0, 1'b1, '{8'd0, 64'd0}},
    '{ROW_ITEM, CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, REG_FIXED_STEP, 32'd0, 1'b0,
      '{8'd0, 64'd0}},
    // zero step behaves as one
    '{ROW_WRITE, CMD_QUERY, 64'd0, 64'd0, REG_FIXED_STEP, 32'd0, 1'b0, '{8'd0, 64'd0}},
    '{ROW_ITEM, CMD_QUERY, 64'd5, 64'd0, REG_FIXED_STEP, 32'd0, 1'b0, '{8'd0, 64'd0}},
    // cap of zero empties the budget on the next due query
    '{ROW_WRITE, CMD_QUERY, 64'd0, 64'd0, REG_MAX_BUDGET, 32'd0, 1'b0, '{8'd0, 64'd0}},
    '{ROW_ITEM, CMD_QUERY, 64'd10, 64'd0, REG_FIXED_STEP, 32'd0, 1'b0, '{8'd0, 64'd0}},
    '{ROW_ITEM, CMD_QUERY, 64'd20, 64'd0, REG_FIXED_STEP, 32'd0, 1'b1, '{8'd0, 64'd0}},
    '{ROW_WRITE, CMD_QUERY, 64'd0, 64'd0, REG_MAX_BUDGET, 32'd255, 1'b0, '{8'd0, 64'd0}},
    '{ROW_ITEM, CMD_QUERY, 64'd30, 64'd0, REG_FIXED_STEP, 32'd0, 1'b1, '{8'd0, 64'd0}},
    '{ROW_ITEM, CMD_QUERY, 64'd40, 64'd0, REG_FIXED_STEP, 32'd0, 1'b0, '{8'd0, 64'd0}}
  };

  // phase 6 is drawn at random when it starts
  cfg_t phase_cfgs [NUM_PHASES] = '{
    '{32'd16667, 8'd200, 8'd4},
    '{32'd1, 8'd255, 8'd255},
    '{32'hFFFF_FFFF, 8'd1, 8'd1},
    '{32'd0, 8'd12, 8'd3},
    '{32'd1000, 8'd60, 8'd0},
    '{32'd250, 8'd0, 8'd9},
    '{32'd16667, 8'd200, 8'd4},
    '{32'd33333, 8'd30, 8'd2}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  ftcs_in_if  in_if ();
  ftcs_out_if out_if ();

  fixed_timestep_catchup_scheduler u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // scheduler state as the testbench sees it
  cfg_t                sched_cfg;
  logic [TIME_W-1:0]   sched_lut;
  logic                sched_first;
  logic [BUDGET_W-1:0] sched_budget;

  update_t expected_updates[$];

  // set on a due query so the stimulus can catch the last update time up
  logic              catchup_pending;
  logic [TIME_W-1:0] catchup_us;

  logic        hold_request;
  int unsigned burst_left;
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned n_items, n_due, n_widened, n_zero_budget, n_not_due, n_behind;
  int unsigned n_advance, n_writes;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] ceil_quot(logic [63:0] num, logic [63:0] den);
    return (num - 64'd1) / den + 64'd1;
  endfunction

  function automatic void refill_budget(logic [63:0] spent);
    logic [63:0] b;
    b = {56'd0, sched_budget};
    b = (spent <= b) ? b - spent : 64'd0;
    b = b + {56'd0, sched_cfg.refill_per_frame};
    if (b > {56'd0, sched_cfg.max_budget}) b = {56'd0, sched_cfg.max_budget};
    sched_budget = b[BUDGET_W-1:0];
  endfunction

  function automatic update_t predict_schedule(logic c, logic [63:0] nw, logic [63:0] av);
    update_t     res;
    logic [63:0] stp, elapsed, cnt;
    res = '0;
    if (c == CMD_ADVANCE) begin
      sched_lut = sched_lut + av;
      n_advance++;
      return res;
    end
    if (sched_first) begin
      sched_lut   = nw;
      sched_first = 1'b0;
    end
    stp = (sched_cfg.fixed_step_us == '0) ? 64'd1 : {32'd0, sched_cfg.fixed_step_us};
    if (nw < sched_lut) begin
      n_behind++;
      return res;
    end
    elapsed = nw - sched_lut;
    if (elapsed < stp) begin
      n_not_due++;
      return res;
    end
    if (sched_budget == '0) begin
      refill_budget(64'd0);
      n_zero_budget++;
      return res;
    end
    cnt = ceil_quot(elapsed, stp);
    // more steps due than budget: widen each step so the budget covers it
    if (cnt > {56'd0, sched_budget}) begin
      stp = ceil_quot(elapsed, {56'd0, sched_budget});
      cnt = ceil_quot(elapsed, stp);
      n_widened++;
    end
    refill_budget(cnt);
    n_due++;
    res.iterations  = cnt[BUDGET_W-1:0];
    res.step_us     = stp;
    catchup_pending = 1'b1;
    catchup_us      = cnt * stp;
    return res;
  endfunction

  // offer one item, predict it on transfer, then maybe pause the sender
  task automatic offer(input logic c, input logic [63:0] nw, input logic [63:0] av,
                       input logic typed, input update_t typed_upd);
    update_t res;
    in_if.valid      <= 1'b1;
    in_if.cmd        <= c;
    in_if.now_us     <= nw;
    in_if.advance_us <= av;
    do @(posedge clk_i); while (!in_if.ready);
    res = predict_schedule(c, nw, av);
    expected_updates.push_back(typed ? typed_upd : res);
    n_items++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_FIXED_STEP: sched_cfg.fixed_step_us    = val;
      REG_MAX_BUDGET: sched_cfg.max_budget       = val[BUDGET_W-1:0];
      REG_REFILL:     sched_cfg.refill_per_frame = val[BUDGET_W-1:0];
      default: ;
    endcase
    n_writes++;
    @(posedge clk_i);
  endtask

  // mostly frame queries followed by a catch-up advance, plus some noise
  task automatic next_random_item(output logic c, output logic [63:0] nw,
                                  output logic [63:0] av);
    int unsigned r, q;
    logic [63:0] stp, k;
    stp = (sched_cfg.fixed_step_us == '0) ? 64'd1 : {32'd0, sched_cfg.fixed_step_us};
    r   = $urandom_range(0, 99);
    q   = $urandom_range(0, 99);
    nw  = rand64();
    av  = rand64();
    if (catchup_pending && r < 70) begin
      c  = CMD_ADVANCE;
      av = catchup_us;
      catchup_pending = 1'b0;
    end else if (r < 88) begin
      c = CMD_QUERY;
      if (q < 10) begin
        nw = sched_lut + rand64() % stp;
      end else if (q < 80) begin
        k  = (q < 55) ? 64'($urandom_range(1, 8)) : 64'($urandom_range(9, 700));
        nw = sched_lut + (k - 64'd1) * stp + 64'd1 + rand64() % stp;
      end else if (q < 90) begin
        nw = sched_lut - 64'd1 - 64'($urandom_range(0, 100000));
      end
    end else begin
      c = CMD_ADVANCE;
      if (q < 50) av = rand64() % (stp * 64'd4);
    end
  endtask

  // result side: stalls on patterns of its own, one long hold on request
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned seg_len;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        mode    = RX_HOLD;
        seg_len = HOLD_CYCLES;
      end else begin
        mode    = rx_mode_e'($urandom_range(0, 3));
        seg_len = (mode == RX_STALL) ? $urandom_range(1, 20) : $urandom_range(4, 60);
      end
      repeat (seg_len) begin
        @(posedge clk_i);
        case (mode)
          RX_OPEN:   out_if.ready <= 1'b1;
          RX_RANDOM: out_if.ready <= ($urandom_range(0, 3) != 0);
          RX_TOGGLE: out_if.ready <= ~out_if.ready;
          default:   out_if.ready <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    update_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_updates.size() == 0) begin
        $error("result transfer with nothing expected: iterations %0d step_us %0d",
               out_if.iterations, out_if.step_us);
        err_count++;
      end else begin
        want = expected_updates.pop_front();
        if (out_if.iterations !== want.iterations) begin
          $error("iterations: expected %0d, got %0d", want.iterations, out_if.iterations);
          err_count++;
        end
        if (out_if.step_us !== want.step_us) begin
          $error("step_us: expected %0d, got %0d", want.step_us, out_if.step_us);
          err_count++;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("cycle limit of %0d reached with %0d results outstanding",
             CYCLE_LIMIT, expected_updates.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    logic        c;
    logic [63:0] nw, av;
    cfg_t        pc;
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.cmd        <= CMD_QUERY;
    in_if.now_us     <= '0;
    in_if.advance_us <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    sched_cfg        = '{FIXED_STEP_RST, MAX_BUDGET_RST, REFILL_RST};
    sched_lut        = '0;
    sched_first      = 1'b1;
    sched_budget     = MAX_BUDGET_RST;
    catchup_pending  = 1'b0;
    catchup_us       = '0;
    hold_request     = 1'b0;
    burst_left       = 0;
    err_count        = 0;
    n_items = 0; n_due = 0; n_widened = 0; n_zero_budget = 0;
    n_not_due = 0; n_behind = 0; n_advance = 0; n_writes = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        drain_results();
        write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
      end else begin
        offer(directed_rows[i].cmd, directed_rows[i].now_us, directed_rows[i].advance_us,
              directed_rows[i].has_exp, directed_rows[i].exp_upd);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      pc = phase_cfgs[ph];
      if (ph == 6) begin
        pc.fixed_step_us    = $urandom_range(1, 100000);
        pc.max_budget       = BUDGET_W'($urandom_range(1, 255));
        pc.refill_per_frame = BUDGET_W'($urandom_range(1, 255));
      end
      drain_results();
      write_reg(REG_FIXED_STEP, pc.fixed_step_us);
      write_reg(REG_MAX_BUDGET, 32'(pc.max_budget));
      write_reg(REG_REFILL, 32'(pc.refill_per_frame));
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // sender keeps offering while the result side holds off
        if (ph == 1 && k == 40) hold_request = 1'b1;
        next_random_item(c, nw, av);
        offer(c, nw, av, 1'b0, '0);
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("ran %0d items: %0d due queries, %0d with widened steps, %0d on an empty budget",
             n_items, n_due, n_widened, n_zero_budget);
    $display("also %0d not due, %0d behind the last update, %0d advances, %0d register writes",
             n_not_due, n_behind, n_advance, n_writes);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
